/* design/ibcm_pkg.sv */
// Shared widths and constants for the IMU bias calibration and magnitude block.
package ibcm_pkg;

  localparam int AXIS_W      = 16;
  localparam int GSUM_W      = 24;
  localparam int CNT_W       = 8;
  localparam int SQ_W        = 32;
  localparam int ROOT_W      = 16;
  localparam int TEMP_W      = 15;
  localparam int GCORR_W     = 17;
  localparam int TNUM_W      = 18;
  localparam int TDEN_W      = 5;
  localparam int TQ_W        = 14;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 136;

  localparam logic [TDEN_W-1:0] TEMP_DEN    = 5'd17;
  localparam logic [TNUM_W-1:0] TEMP_ROUND  = 18'd8;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd3653;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [ROOT_W-1:0]        root_t;

endpackage

/* design/ibcm_sdiv.sv */
// Bit-serial restoring divider by a constant divisor, one quotient bit per cycle.
module ibcm_sdiv #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem, quo[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      rem <= qbit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], qbit};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

/* design/ibcm_sqsum.sv */
// Bit-serial sum of squares of three accelerometer axes, one multiplier bit per cycle.
module ibcm_sqsum (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ibcm_pkg::axis_t ax,
  input  ibcm_pkg::axis_t ay,
  input  ibcm_pkg::axis_t az,
  output logic          busy,
  output ibcm_pkg::sq_t sum
);
  import ibcm_pkg::*;

  localparam int CW = $clog2(AXIS_W + 1);

  logic [CW-1:0]     cnt;
  logic [AXIS_W-1:0] mx, my, mz;
  logic [AXIS_W-1:0] bx, by, bz;
  logic [AXIS_W+1:0] acc;
  logic [AXIS_W-1:0] lo;
  logic [AXIS_W+2:0] s;

  assign s = {1'b0, acc}
           + (bx[0] ? (AXIS_W+3)'(mx) : '0)
           + (by[0] ? (AXIS_W+3)'(my) : '0)
           + (bz[0] ? (AXIS_W+3)'(mz) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(AXIS_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx  <= ax[AXIS_W-1] ? AXIS_W'(-ax) : AXIS_W'(ax);
      my  <= ay[AXIS_W-1] ? AXIS_W'(-ay) : AXIS_W'(ay);
      mz  <= az[AXIS_W-1] ? AXIS_W'(-az) : AXIS_W'(az);
      bx  <= ax[AXIS_W-1] ? AXIS_W'(-ax) : AXIS_W'(ax);
      by  <= ay[AXIS_W-1] ? AXIS_W'(-ay) : AXIS_W'(ay);
      bz  <= az[AXIS_W-1] ? AXIS_W'(-az) : AXIS_W'(az);
      acc <= '0;
      lo  <= '0;
    end else if (cnt != '0) begin
      acc <= s[AXIS_W+2:1];
      lo  <= {s[0], lo[AXIS_W-1:1]};
      bx  <= bx >> 1;
      by  <= by >> 1;
      bz  <= bz >> 1;
    end
  end

  assign busy = (cnt != '0);
  assign sum  = {acc[SQ_W-AXIS_W-1:0], lo};

endmodule

/* design/ibcm_ssqrt.sv */
// Digit-serial integer square root, two radicand bits and one root bit per cycle.
module ibcm_ssqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ibcm_pkg::sq_t   radicand,
  output logic            busy,
  output ibcm_pkg::root_t root
);
  import ibcm_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic [CW-1:0]     cnt;
  sq_t               x;
  logic [ROOT_W:0]   rem;
  root_t             r;
  logic [ROOT_W+2:0] t;
  logic [ROOT_W+2:0] trial;
  logic              rbit;

  assign t     = {rem, x[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, r, 2'b01};
  assign rbit  = (t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(ROOT_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= radicand;
      rem <= '0;
      r   <= '0;
    end else if (cnt != '0) begin
      x   <= {x[SQ_W-3:0], 2'b00};
      rem <= rbit ? (ROOT_W+1)'(t - trial) : (ROOT_W+1)'(t);
      r   <= {r[ROOT_W-2:0], rbit};
    end
  end

  assign busy = (cnt != '0);
  assign root = r;

endmodule

/* design/imu_bias_calibrate_and_magnitude.sv */
// Top level: gyro bias calibration, accelerometer magnitude and temperature scaling.
// Calibration samples are accepted back to back; the last one is followed by the offset division.
// A measured sample passes through bit-serial squaring and then digit-serial square root, with
// the temperature division running alongside, and is then registered as a result; the next
// sample is accepted only after that. The result register lets the next sample enter while a result waits.
// Reset clears the calibration count, sums, offsets and all handshake state.
module imu_bias_calibrate_and_magnitude #(
  parameter int CAL_SAMPLES = 200
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // accel_x, accel_y, accel_z, temp_raw, gyro_x, gyro_y, gyro_z
  input  logic [ibcm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_accel_x, out_accel_y, out_accel_z, accel_magnitude, temp_centideg,
  // gyro_x_corrected, gyro_y_corrected, gyro_z_corrected, zero padding
  output logic [ibcm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import ibcm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OFFS = 3'd1;
  localparam logic [2:0] ST_OWAIT = 3'd2;
  localparam logic [2:0] ST_SQ = 3'd3;
  localparam logic [2:0] ST_RT = 3'd4;
  localparam logic [2:0] ST_FIN = 3'd5;

  localparam logic [CNT_W-1:0] CAL_N = CNT_W'(CAL_SAMPLES);

  logic [2:0] state;
  logic [CNT_W-1:0] calib_count;
  logic signed [GSUM_W-1:0] gyro_sum_x, gyro_sum_y, gyro_sum_z;
  axis_t offset_x, offset_y, offset_z;

  axis_t in_ax, in_ay, in_az, in_tr, in_gx, in_gy, in_gz;
  axis_t ax, ay, az, gx, gy, gz;
  logic temp_neg;
  logic accept, calibrating;

  logic [AXIS_W-1:0] tr_abs;
  logic [TNUM_W-1:0] tnum;
  logic [TNUM_W-1:0] tquo;
  logic tdiv_busy;

  logic sq_start, sq_busy;
  sq_t sq_sum;
  logic rt_start, rt_busy;
  root_t mag;

  logic od_start;
  logic odx_busy, ody_busy, odz_busy;
  logic [GSUM_W-1:0] qx, qy, qz;

  logic [TEMP_W-1:0] temp_val;
  logic [GCORR_W-1:0] gcx, gcy, gcz;

  assign in_ax = s_axis_tdata[15:0];
  assign in_ay = s_axis_tdata[31:16];
  assign in_az = s_axis_tdata[47:32];
  assign in_tr = s_axis_tdata[63:48];
  assign in_gx = s_axis_tdata[79:64];
  assign in_gy = s_axis_tdata[95:80];
  assign in_gz = s_axis_tdata[111:96];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign calibrating   = (calib_count < CAL_N);

  assign tr_abs   = in_tr[AXIS_W-1] ? AXIS_W'(-in_tr) : AXIS_W'(in_tr);
  assign tnum     = {tr_abs, 2'b00} + TNUM_W'(tr_abs) + TEMP_ROUND;
  assign sq_start = accept && !calibrating;
  assign rt_start = (state == ST_SQ) && !sq_busy;
  assign od_start = (state == ST_OFFS);

  ibcm_sqsum u_sqsum (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .ax    (in_ax),
    .ay    (in_ay),
    .az    (in_az),
    .busy  (sq_busy),
    .sum   (sq_sum)
  );

  ibcm_ssqrt u_ssqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (sq_sum),
    .busy     (rt_busy),
    .root     (mag)
  );

  ibcm_sdiv #(.NUM_W(TNUM_W), .DEN_W(TDEN_W)) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .num      (tnum),
    .den      (TEMP_DEN),
    .busy     (tdiv_busy),
    .quotient (tquo)
  );

  ibcm_sdiv #(.NUM_W(GSUM_W), .DEN_W(CNT_W)) u_odiv_x (
    .clk      (clk),
    .rst      (rst),
    .start    (od_start),
    .num      (gyro_sum_x[GSUM_W-1] ? GSUM_W'(-gyro_sum_x) : GSUM_W'(gyro_sum_x)),
    .den      (CAL_N),
    .busy     (odx_busy),
    .quotient (qx)
  );

  ibcm_sdiv #(.NUM_W(GSUM_W), .DEN_W(CNT_W)) u_odiv_y (
    .clk      (clk),
    .rst      (rst),
    .start    (od_start),
    .num      (gyro_sum_y[GSUM_W-1] ? GSUM_W'(-gyro_sum_y) : GSUM_W'(gyro_sum_y)),
    .den      (CAL_N),
    .busy     (ody_busy),
    .quotient (qy)
  );

  ibcm_sdiv #(.NUM_W(GSUM_W), .DEN_W(CNT_W)) u_odiv_z (
    .clk      (clk),
    .rst      (rst),
    .start    (od_start),
    .num      (gyro_sum_z[GSUM_W-1] ? GSUM_W'(-gyro_sum_z) : GSUM_W'(gyro_sum_z)),
    .den      (CAL_N),
    .busy     (odz_busy),
    .quotient (qz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      calib_count <= '0;
      gyro_sum_x  <= '0;
      gyro_sum_y  <= '0;
      gyro_sum_z  <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (calibrating) begin
              gyro_sum_x  <= gyro_sum_x + GSUM_W'(in_gx);
              gyro_sum_y  <= gyro_sum_y + GSUM_W'(in_gy);
              gyro_sum_z  <= gyro_sum_z + GSUM_W'(in_gz);
              calib_count <= calib_count + 1'b1;
              if (calib_count + 1'b1 == CAL_N) begin
                state <= ST_OFFS;
              end
            end else begin
              state <= ST_SQ;
            end
          end
        end
        ST_OFFS: begin
          state <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (!odx_busy && !ody_busy && !odz_busy) begin
            offset_x <= gyro_sum_x[GSUM_W-1] ? AXIS_W'(-qx) : AXIS_W'(qx);
            offset_y <= gyro_sum_y[GSUM_W-1] ? AXIS_W'(-qy) : AXIS_W'(qy);
            offset_z <= gyro_sum_z[GSUM_W-1] ? AXIS_W'(-qz) : AXIS_W'(qz);
            state    <= ST_IDLE;
          end
        end
        ST_SQ: begin
          if (!sq_busy) begin
            state <= ST_RT;
          end
        end
        ST_RT: begin
          if (!rt_busy && !tdiv_busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sq_start) begin
      ax       <= in_ax;
      ay       <= in_ay;
      az       <= in_az;
      gx       <= in_gx;
      gy       <= in_gy;
      gz       <= in_gz;
      temp_neg <= in_tr[AXIS_W-1];
    end
  end

  assign temp_val = (temp_neg ? TEMP_W'(-{1'b0, tquo[TQ_W-1:0]})
                              : TEMP_W'({1'b0, tquo[TQ_W-1:0]})) + TEMP_OFFSET;
  assign gcx = {gx[AXIS_W-1], gx} - {offset_x[AXIS_W-1], offset_x};
  assign gcy = {gy[AXIS_W-1], gy} - {offset_y[AXIS_W-1], offset_y};
  assign gcz = {gz[AXIS_W-1], gz} - {offset_z[AXIS_W-1], offset_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {6'b000000, gcz, gcy, gcx, temp_val, mag, az, ay, ax};
    end
  end

endmodule

/* tb/tb_imu_bias_calibrate_and_magnitude.sv */
// Self-checking testbench for the IMU bias calibration and accelerometer magnitude block.
module tb_imu_bias_calibrate_and_magnitude;
  import ibcm_pkg::*;

  localparam int CAL_SAMPLES   = 200;
  localparam int RANDOM_ITEMS  = 1234;
  localparam int SETTLE_CYCLES = 80;
  localparam int SHOWN_LIMIT   = 10;
  localparam int IDLE_PERCENT  = 18;
  localparam int TEMP_BASE     = 3653;

  typedef struct {
    axis_t ax, ay, az, temp, gx, gy, gz;
  } imu_sample_t;

  typedef struct {
    logic [AXIS_W-1:0]  ax, ay, az;
    logic [ROOT_W-1:0]  mag;
    logic [TEMP_W-1:0]  temp;
    logic [GCORR_W-1:0] gx, gy, gz;
    logic [OUT_TDATA_W-3*AXIS_W-ROOT_W-TEMP_W-3*GCORR_W-1:0] pad;
  } motion_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  motion_result_t expected_results[$];
  int  calib_taken = 0;
  int  gyro_bias_sum[3] = '{0, 0, 0};
  int  gyro_bias[3] = '{0, 0, 0};
  int  errors = 0;
  int  shown = 0;
  int  calib_sent = 0;
  int  measured_sent = 0;
  int  results_checked = 0;
  bit  no_idle = 1'b0;

  imu_bias_calibrate_and_magnitude #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    #(8 * 600_000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic imu_sample_t make_sample(int ax, int ay, int az, int t,
                                              int gx, int gy, int gz);
    imu_sample_t s;
    s.ax = axis_t'(ax);
    s.ay = axis_t'(ay);
    s.az = axis_t'(az);
    s.temp = axis_t'(t);
    s.gx = axis_t'(gx);
    s.gy = axis_t'(gy);
    s.gz = axis_t'(gz);
    return s;
  endfunction

  function automatic int any_value();
    return int'(axis_t'($urandom));
  endfunction

  function automatic motion_result_t predict_motion(imu_sample_t s);
    motion_result_t r;
    longint sum_sq;
    longint trial;
    longint root;
    int     num;
    int     q;
    sum_sq = longint'(s.ax) * longint'(s.ax) + longint'(s.ay) * longint'(s.ay)
           + longint'(s.az) * longint'(s.az);
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum_sq) begin
        root = trial;
      end
    end
    num = int'(s.temp) * 5;
    if (num >= 0) begin
      q = (num + 8) / 17;
    end else begin
      q = -((-num + 8) / 17);
    end
    r.ax = s.ax;
    r.ay = s.ay;
    r.az = s.az;
    r.mag = ROOT_W'(root);
    r.temp = TEMP_W'(q + TEMP_BASE);
    r.gx = GCORR_W'(int'(s.gx) - gyro_bias[0]);
    r.gy = GCORR_W'(int'(s.gy) - gyro_bias[1]);
    r.gz = GCORR_W'(int'(s.gz) - gyro_bias[2]);
    r.pad = '0;
    return r;
  endfunction

  // Calibration samples only update the bias; later samples each owe one result.
  task automatic send_sample(imu_sample_t s);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.gz, s.gy, s.gx, s.temp, s.az, s.ay, s.ax};
    do @(posedge clk); while (!s_axis_tready);
    if (calib_taken < CAL_SAMPLES) begin
      gyro_bias_sum[0] += int'(s.gx);
      gyro_bias_sum[1] += int'(s.gy);
      gyro_bias_sum[2] += int'(s.gz);
      calib_taken++;
      calib_sent++;
      if (calib_taken == CAL_SAMPLES) begin
        for (int i = 0; i < 3; i++) begin
          gyro_bias[i] = gyro_bias_sum[i] / CAL_SAMPLES;
        end
      end
    end else begin
      expected_results.push_back(predict_motion(s));
      measured_sent++;
    end
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      if (shown < SHOWN_LIMIT) begin
        shown++;
        $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                 name, results_checked, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    motion_result_t got;
    motion_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      {got.pad, got.gz, got.gy, got.gx, got.temp, got.mag, got.az, got.ay, got.ax} =
        m_axis_tdata;
      if (expected_results.size() == 0) begin
        errors++;
        if (shown < SHOWN_LIMIT) begin
          shown++;
          $display("Result transfer with no sample outstanding: %h", m_axis_tdata);
        end
      end else begin
        want = expected_results.pop_front();
        compare_field("out_accel_x", want.ax, got.ax);
        compare_field("out_accel_y", want.ay, got.ay);
        compare_field("out_accel_z", want.az, got.az);
        compare_field("accel_magnitude", want.mag, got.mag);
        compare_field("temp_centideg", want.temp, got.temp);
        compare_field("gyro_x_corrected", want.gx, got.gx);
        compare_field("gyro_y_corrected", want.gy, got.gy);
        compare_field("gyro_z_corrected", want.gz, got.gz);
        compare_field("padding", want.pad, got.pad);
      end
      results_checked++;
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // The x bias is pulled negative and y positive so that truncation towards zero is seen
  // on both signs; z spans the full range, with both extremes in the first two samples.
  task automatic test_calibration();
    send_sample(make_sample(any_value(), any_value(), any_value(), any_value(),
                            32767, 32767, 32767));
    send_sample(make_sample(any_value(), any_value(), any_value(), any_value(),
                            -32768, -32768, -32768));
    for (int i = 2; i < CAL_SAMPLES; i++) begin
      send_sample(make_sample(any_value(), any_value(), any_value(), any_value(),
                              int'($urandom_range(600)) - 450,
                              int'($urandom_range(900)) - 200,
                              any_value()));
    end
  endtask

  task automatic test_directed();
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, 0, 0, 1, gyro_bias[0], gyro_bias[1], gyro_bias[2]));
    send_sample(make_sample(0, 32767, 0, 2, -1, 1, 0));
    send_sample(make_sample(0, 0, -32768, -1, 1, -1, -1));
    send_sample(make_sample(3, 4, 12, -2, 100, -100, 0));
    send_sample(make_sample(1, 1, 1, 340, 0, 0, 0));
    send_sample(make_sample(2, 2, 2, -340, 0, 0, 0));
    send_sample(make_sample(1, 2, 2, 3, 0, 0, 0));
    send_sample(make_sample(0, 0, 2048, -12403, 0, 0, 0));
    send_sample(make_sample(-2048, 0, 0, 17, -32768, 32767, -32768));
    send_sample(make_sample(-1, -1, -1, -17, 32767, -32768, 32767));
    send_sample(make_sample(32767, -32768, 32767, 1700, 5, -5, 5));
    send_sample(make_sample(181, 181, 181, -3, 0, 0, 0));
    send_sample(make_sample(-32768, -32768, 32767, 4, 0, 0, 0));
  endtask

  // Half the samples are full-range noise; the rest sit near one g and room temperature, or
  // mix the extreme codes per field.
  task automatic test_random();
    int values[7];
    int kind;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 500 && n < 800);
      kind = $urandom_range(3);
      for (int f = 0; f < 7; f++) begin
        case (kind)
          2: begin
            if (f < 3) begin
              values[f] = (f == 2 ? 2048 : 0) + int'($urandom_range(400)) - 200;
            end else if (f == 3) begin
              values[f] = -4000 + int'($urandom_range(3000));
            end else begin
              values[f] = gyro_bias[f-4] + int'($urandom_range(60)) - 30;
            end
          end
          3: begin
            case ($urandom_range(5))
              0: values[f] = -32768;
              1: values[f] = 32767;
              2: values[f] = -1;
              3: values[f] = 0;
              4: values[f] = 1;
              default: values[f] = any_value();
            endcase
          end
          default: values[f] = any_value();
        endcase
      end
      send_sample(make_sample(values[0], values[1], values[2], values[3],
                              values[4], values[5], values[6]));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_calibration();
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += expected_results.size();
    $display("Sent %0d calibration samples and %0d measured samples; %0d results checked.",
             calib_sent, measured_sent, results_checked);
    $display("Gyro bias learnt: x %0d, y %0d, z %0d; %0d mismatches.",
             gyro_bias[0], gyro_bias[1], gyro_bias[2], errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ibcm_pkg.sv
design/ibcm_sdiv.sv
design/ibcm_sqsum.sv
design/ibcm_ssqrt.sv
design/imu_bias_calibrate_and_magnitude.sv
tb/tb_imu_bias_calibrate_and_magnitude.sv
